// File: hw/rtl/bmhpq_pkg.sv
`default_nettype none

package bmhpq_pkg;

   // Request codes carried in req_type.
   localparam logic [1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [1:0] REQ_DEQUEUE = 2'd1;
   localparam logic [1:0] REQ_PEEK    = 2'd2;
   localparam logic [1:0] REQ_SIZE    = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int unsigned DATA_W        = 32;
   localparam int unsigned ENTRY_COUNT_W = 5;

   // One request.
   typedef struct packed {
      logic [1:0]               req_type;
      logic signed [DATA_W-1:0] item_value;
      logic signed [DATA_W-1:0] item_priority;
   } bmhpq_req_type;

   // One result.
   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] out_value;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } bmhpq_rsp_type;

   // One heap slot.
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } bmhpq_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;       // latch a new request
      logic       up_init;    // append: pos gets count, count increments
      logic       rd_root;    // read slot 0 on port A
      logic       rd_last;    // read last slot on port B
      logic       dq_init;    // take root value and last entry, count decrements
      logic       peek_cap;   // result value comes from port A
      logic       rd_up;      // read parent of pos on port A
      logic       rd_down;    // read children of pos on ports A and B
      logic       wr_hold;    // write the held entry at pos
      logic       up_move;    // move parent down to pos, pos goes to parent
      logic       down_move;  // move larger child up to pos, pos goes to child
      logic       respond;    // issue the result
      logic [1:0] status;     // status code of the result
   } bmhpq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] req_type;
      logic       empty;
      logic       full;
      logic       at_root;
      logic       up_stop;
      logic       down_stop;
   } bmhpq_stat_type;

endpackage

`default_nettype wire

// File: hw/rtl/bmhpq_ctrl.sv
`default_nettype none

module bmhpq_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  bmhpq_pkg::bmhpq_stat_type stat,
   output bmhpq_pkg::bmhpq_cmd_type  cmd
);
   import bmhpq_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_ROOT     = 3'd2;
   localparam logic [2:0] S_DQ_LOAD  = 3'd3;
   localparam logic [2:0] S_UP_CHECK = 3'd4;
   localparam logic [2:0] S_UP_EVAL  = 3'd5;
   localparam logic [2:0] S_DN_READ  = 3'd6;
   localparam logic [2:0] S_DN_EVAL  = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = STATUS_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.req_type)
               REQ_ENQUEUE: begin
                  if (stat.full) begin
                     cmd.status  = STATUS_FULL;
                     cmd.respond = 1'b1;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.up_init = 1'b1;
                     state_in    = S_UP_CHECK;
                  end
               end
               REQ_DEQUEUE: begin
                  if (stat.empty) begin
                     cmd.status  = STATUS_EMPTY;
                     cmd.respond = 1'b1;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.rd_root = 1'b1;
                     cmd.rd_last = 1'b1;
                     state_in    = S_DQ_LOAD;
                  end
               end
               REQ_PEEK: begin
                  if (stat.empty) begin
                     cmd.status  = STATUS_EMPTY;
                     cmd.respond = 1'b1;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.rd_root = 1'b1;
                     state_in    = S_ROOT;
                  end
               end
               default: begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
               end
            endcase
         end
         S_ROOT: begin
            cmd.peek_cap = 1'b1;
            cmd.respond  = 1'b1;
            state_in     = S_IDLE;
         end
         S_DQ_LOAD: begin
            cmd.dq_init = 1'b1;
            state_in    = S_DN_READ;
         end
         S_UP_CHECK: begin
            if (stat.at_root) begin
               cmd.wr_hold = 1'b1;
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.rd_up = 1'b1;
               state_in  = S_UP_EVAL;
            end
         end
         S_UP_EVAL: begin
            if (stat.up_stop) begin
               cmd.wr_hold = 1'b1;
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.up_move = 1'b1;
               state_in    = S_UP_CHECK;
            end
         end
         S_DN_READ: begin
            cmd.rd_down = 1'b1;
            state_in    = S_DN_EVAL;
         end
         S_DN_EVAL: begin
            if (stat.down_stop) begin
               cmd.wr_hold = 1'b1;
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.down_move = 1'b1;
               state_in      = S_DN_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/bmhpq_dp.sv
`default_nettype none

module bmhpq_dp #(
   parameter int unsigned DEPTH = 16
) (
   input  wire                       clock,
   input  wire                       reset,
   input  bmhpq_pkg::bmhpq_req_type  req,
   input  bmhpq_pkg::bmhpq_cmd_type  cmd,
   output bmhpq_pkg::bmhpq_stat_type stat,
   output logic                      rsp_valid,
   output bmhpq_pkg::bmhpq_rsp_type  rsp
);
   import bmhpq_pkg::*;

   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned XW = IW + 2;

   // Heap storage and its registered read ports.
   bmhpq_entry_type heap_mem_ff [DEPTH];
   bmhpq_entry_type rd_a_ff;
   bmhpq_entry_type rd_b_ff;

   logic [IW-1:0]    rd_a_addr;
   logic [IW-1:0]    rd_b_addr;
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   bmhpq_entry_type  wr_data;

   // Working registers.
   logic [1:0]               req_type_ff;
   bmhpq_entry_type          hold_ff;
   logic signed [DATA_W-1:0] val_ff;
   logic [IW-1:0]            pos_ff;
   logic [CW-1:0]            count_ff;
   logic                     rsp_valid_ff;
   bmhpq_rsp_type            rsp_ff;

   logic [IW-1:0] pos_m1;
   logic [IW-1:0] up_slot;
   logic [XW-1:0] child_l;
   logic [XW-1:0] child_r;
   logic [XW-1:0] count_x;
   logic          l_ok;
   logic          r_ok;
   logic          l_gt;
   logic          r_gt;
   logic signed [DATA_W-1:0] best_prio;

   // Tree index arithmetic.
   assign pos_m1     = pos_ff - IW'(1);
   assign up_slot    = pos_m1 >> 1;
   assign child_l    = {1'b0, pos_ff, 1'b1};
   assign child_r    = child_l + XW'(1);
   assign count_x    = XW'(count_ff);
   assign l_ok       = (child_l < count_x);
   assign r_ok       = (child_r < count_x);

   // Child selection: left wins ties, a child moves only if strictly greater.
   assign l_gt      = l_ok && ($signed(rd_a_ff.prio) > $signed(hold_ff.prio));
   assign best_prio = l_gt ? rd_a_ff.prio : hold_ff.prio;
   assign r_gt      = r_ok && ($signed(rd_b_ff.prio) > $signed(best_prio));

   // Status toward the controller.
   always_comb begin
      stat.req_type  = req_type_ff;
      stat.empty     = (count_ff == '0);
      stat.full      = (count_ff == CW'(DEPTH));
      stat.at_root   = (pos_ff == '0);
      stat.up_stop   = ($signed(rd_a_ff.prio) > $signed(hold_ff.prio));
      stat.down_stop = !l_gt && !r_gt;
   end

   // Read address selection.
   always_comb begin
      rd_a_addr = '0;
      rd_b_addr = '0;
      if (cmd.rd_last) begin
         rd_b_addr = IW'(count_ff - CW'(1));
      end
      if (cmd.rd_up) begin
         rd_a_addr = up_slot;
      end
      if (cmd.rd_down) begin
         rd_a_addr = child_l[IW-1:0];
         rd_b_addr = child_r[IW-1:0];
      end
   end

   // Write port selection.
   always_comb begin
      wr_en   = cmd.wr_hold || cmd.up_move || cmd.down_move;
      wr_addr = pos_ff;
      wr_data = hold_ff;
      if (cmd.up_move) begin
         wr_data = rd_a_ff;
      end else if (cmd.down_move) begin
         wr_data = r_gt ? rd_b_ff : rd_a_ff;
      end
   end

   // Heap memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem_ff[rd_a_addr];
      rd_b_ff <= heap_mem_ff[rd_b_addr];
   end

   // Request, held entry, position and result value.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff           <= req.req_type;
         hold_ff.value         <= req.item_value;
         hold_ff.prio          <= req.item_priority;
         val_ff                <= '0;
      end
      if (cmd.up_init) begin
         pos_ff <= IW'(count_ff);
      end
      if (cmd.dq_init) begin
         val_ff  <= rd_a_ff.value;
         hold_ff <= rd_b_ff;
         pos_ff  <= '0;
      end
      if (cmd.up_move) begin
         pos_ff <= up_slot;
      end
      if (cmd.down_move) begin
         pos_ff <= r_gt ? child_r[IW-1:0] : child_l[IW-1:0];
      end
   end

   // Stored entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.up_init) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.dq_init) begin
         count_ff <= count_ff - CW'(1);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.status      <= cmd.status;
         rsp_ff.out_value   <= cmd.peek_cap ? rd_a_ff.value : val_ff;
         rsp_ff.entry_count <= ENTRY_COUNT_W'(count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// File: hw/rtl/binary_max_heap_priority_queue_core.sv
// A size query, a full enqueue or an empty dequeue or peek is answered at decode; a peek
// first reads the root; an enqueue appends and sifts up, and a dequeue moves the last
// entry to the root and sifts it down, each one level at a time until it settles.
// One request is in work at a time; busy drops as the result strobe is shown.
// Synchronous reset empties the queue; slot contents are left as they were.
`default_nettype none

module binary_max_heap_priority_queue_core #(
   parameter int unsigned DEPTH = 16
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  bmhpq_pkg::bmhpq_req_type req_data,
   output logic                     rsp_valid,
   output bmhpq_pkg::bmhpq_rsp_type rsp_data
);
   import bmhpq_pkg::*;

   bmhpq_cmd_type  cmd;
   bmhpq_stat_type stat;

   // Sequencer.
   bmhpq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Heap storage and arithmetic.
   bmhpq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

   // An accepted request makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // The result strobe is shown only once the block has gone idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   // Results never come in consecutive cycles.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   // Failed requests carry a zero value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_FULL || rsp_data.status == STATUS_EMPTY))
         |-> (rsp_data.out_value == '0))
      else $error("failed request returned a nonzero value");

endmodule

`default_nettype wire
